// ----- rtl/core/session_table_snapshot_sync_assert.svh -----
// ---------------------------------------------------------------------------
// Session table assertion macros
// Shorthand for clocked, reset-qualified property checks on the top level.
// ---------------------------------------------------------------------------
`ifndef SESSION_TABLE_SNAPSHOT_SYNC_ASSERT_SVH
`define SESSION_TABLE_SNAPSHOT_SYNC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sts_pkg.sv -----
// ---------------------------------------------------------------------------
// Session table package
// Opcodes, outcome codes, status codes, shared structs and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_UPSERT     = 3'd2,
        OP_SNAP_BEGIN = 3'd3,
        OP_SNAP_END   = 3'd4
    } t_opcode;

    typedef enum logic [3:0] {
        OC_UPDATED   = 4'd0,
        OC_INSERTED  = 4'd1,
        OC_DROPPED   = 4'd2,
        OC_REMOVED   = 4'd3,
        OC_MISS      = 4'd4,
        OC_CLEARED   = 4'd5,
        OC_MARKED    = 4'd6,
        OC_SWEPT     = 4'd7,
        OC_NOP       = 4'd8
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_APPLY
    } t_state;

    // Raw status bytes.
    localparam logic [7:0] CH_THINKING = 8'h54;
    localparam logic [7:0] CH_CODING   = 8'h43;
    localparam logic [7:0] CH_TESTING  = 8'h56;
    localparam logic [7:0] CH_ERROR    = 8'h45;
    localparam logic [7:0] CH_IDLE     = 8'h49;

    // Stored status codes.
    localparam logic [2:0] STAT_THINKING = 3'd0;
    localparam logic [2:0] STAT_CODING   = 3'd1;
    localparam logic [2:0] STAT_TESTING  = 3'd2;
    localparam logic [2:0] STAT_ERROR    = 3'd3;
    localparam logic [2:0] STAT_IDLE     = 3'd4;

    // Load tiers and their upper bounds.
    localparam logic [2:0] TIER_NONE    = 3'd0;
    localparam logic [2:0] TIER_ONE     = 3'd1;
    localparam logic [2:0] TIER_LIGHT   = 3'd2;
    localparam logic [2:0] TIER_SEVERAL = 3'd3;
    localparam logic [2:0] TIER_HEAVY   = 3'd4;
    localparam logic [7:0] TIER_LIGHT_MAX   = 8'd3;
    localparam logic [7:0] TIER_SEVERAL_MAX = 8'd6;

    typedef struct packed {
        logic [2:0]  status;
        logic        done;
        logic [31:0] elapsed;
    } t_entry_meta;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic cmp_en;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        t_outcome   outcome;
        logic [2:0] slot_index;
        logic [3:0] active_count;
        logic [2:0] load_tier;
        logic       structure_changed;
    } t_result;

    function automatic logic [2:0] sts_status_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_THINKING: code = STAT_THINKING;
            CH_CODING:   code = STAT_CODING;
            CH_TESTING:  code = STAT_TESTING;
            CH_ERROR:    code = STAT_ERROR;
            CH_IDLE:     code = STAT_IDLE;
            default:     code = STAT_THINKING;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] sts_load_tier(input logic [7:0] n);
        logic [2:0] tier;
        priority if (n == 8'd0) begin
            tier = TIER_NONE;
        end else if (n == 8'd1) begin
            tier = TIER_ONE;
        end else if (n <= TIER_LIGHT_MAX) begin
            tier = TIER_LIGHT;
        end else if (n <= TIER_SEVERAL_MAX) begin
            tier = TIER_SEVERAL;
        end else begin
            tier = TIER_HEAVY;
        end
        return tier;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sts_if.sv -----
// ---------------------------------------------------------------------------
// Session table channel interfaces
// Valid/ready command channel and result channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface sts_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] session_key;
    logic [7:0]  status_char;
    logic [31:0] elapsed_seconds;

    modport source (
        output valid, opcode, session_key, status_char, elapsed_seconds,
        input  ready
    );
    modport sink (
        input  valid, opcode, session_key, status_char, elapsed_seconds,
        output ready
    );
endinterface

interface sts_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] outcome;
    logic [2:0] slot_index;
    logic [3:0] active_count;
    logic [2:0] load_tier;
    logic       structure_changed;

    modport source (
        output valid, outcome, slot_index, active_count, load_tier, structure_changed,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot_index, active_count, load_tier, structure_changed,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/sts_datapath.sv -----
// ---------------------------------------------------------------------------
// Session table datapath
// Entry storage, key compare, scan accumulators and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_datapath import sts_pkg::*; #(
    parameter  int TABLE_SLOTS = 8,
    parameter  int KEY_BITS    = 64,
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [SLOT_W-1:0] i_rd_idx,
    input  logic [SLOT_W-1:0] i_cmp_idx,
    input  logic [2:0]        i_opcode,
    input  logic [63:0]       i_session_key,
    input  logic [7:0]        i_status_char,
    input  logic [31:0]       i_elapsed_seconds,
    output t_result           o_result
);

    logic [TABLE_SLOTS-1:0] r_used;
    logic [TABLE_SLOTS-1:0] r_seen;
    logic [KEY_BITS-1:0]    r_key_mem  [TABLE_SLOTS];
    t_entry_meta            r_meta_mem [TABLE_SLOTS];

    logic [KEY_BITS-1:0] r_key_rd;
    t_opcode             r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [2:0]          r_status;
    logic [31:0]         r_elapsed;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_hit_idx;
    logic                r_free;
    logic [SLOT_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]    r_count;
    logic                r_any_drop;
    t_result             r_result;

    logic                   cmp_used;
    logic                   cmp_seen;
    logic                   cmp_hit;
    logic                   cmp_kept;
    logic                   cmp_drop;
    logic [TABLE_SLOTS-1:0] n_used;
    logic [TABLE_SLOTS-1:0] n_seen;
    logic                   wr_key;
    logic                   wr_meta;
    logic [SLOT_W-1:0]      wr_slot;
    logic [SLOT_W-1:0]      res_slot;
    t_outcome               res_outcome;
    logic                   res_changed;
    logic [CNT_W-1:0]       n_count;
    logic [7:0]             count_ext;
    t_entry_meta            wr_meta_data;

    // Per-slot scan step: what the slot contributes to the surviving count.
    always_comb begin
        cmp_used = r_used[i_cmp_idx];
        cmp_seen = r_seen[i_cmp_idx];
        cmp_hit  = cmp_used && (r_key_rd == r_key);
        unique case (r_op)
            OP_CLEAR: begin
                cmp_kept = 1'b0;
                cmp_drop = cmp_used;
            end
            OP_SNAP_END: begin
                cmp_kept = cmp_used && cmp_seen;
                cmp_drop = cmp_used && !cmp_seen;
            end
            default: begin
                cmp_kept = cmp_used;
                cmp_drop = 1'b0;
            end
        endcase
    end

    // Commit decision once the scan is complete.
    always_comb begin
        n_used      = r_used;
        n_seen      = r_seen;
        wr_key      = 1'b0;
        wr_meta     = 1'b0;
        wr_slot     = r_hit_idx;
        res_slot    = '0;
        res_outcome = OC_NOP;
        res_changed = 1'b0;
        n_count     = r_count;
        unique case (r_op)
            OP_CLEAR: begin
                n_used      = '0;
                res_outcome = OC_CLEARED;
                res_changed = r_any_drop;
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    n_used[r_hit_idx] = 1'b0;
                    res_slot          = r_hit_idx;
                    res_outcome       = OC_REMOVED;
                    res_changed       = 1'b1;
                    n_count           = r_count - CNT_W'(1);
                end else begin
                    res_outcome = OC_MISS;
                end
            end
            OP_UPSERT: begin
                if (r_hit) begin
                    wr_meta           = 1'b1;
                    n_seen[r_hit_idx] = 1'b1;
                    res_slot          = r_hit_idx;
                    res_outcome       = OC_UPDATED;
                end else if (r_free) begin
                    wr_slot            = r_free_idx;
                    wr_key             = 1'b1;
                    wr_meta            = 1'b1;
                    n_used[r_free_idx] = 1'b1;
                    n_seen[r_free_idx] = 1'b1;
                    res_slot           = r_free_idx;
                    res_outcome        = OC_INSERTED;
                    res_changed        = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                end else begin
                    res_outcome = OC_DROPPED;
                end
            end
            OP_SNAP_BEGIN: begin
                n_seen      = r_seen & ~r_used;
                res_outcome = OC_MARKED;
            end
            OP_SNAP_END: begin
                n_used      = r_used & r_seen;
                res_outcome = OC_SWEPT;
                res_changed = r_any_drop;
            end
            default: begin
                res_outcome = OC_NOP;
            end
        endcase
        count_ext    = 8'(n_count);
        wr_meta_data = '{status: r_status, done: (r_status == STAT_IDLE),
                         elapsed: r_elapsed};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_seen <= '0;
        end else if (i_cmd.apply) begin
            r_used <= n_used;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && wr_key) begin
            r_key_mem[wr_slot] <= r_key;
        end
        if (i_cmd.apply && wr_meta) begin
            r_meta_mem[wr_slot] <= wr_meta_data;
        end
        if (i_cmd.rd_en) begin
            r_key_rd <= r_key_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_opcode'(i_opcode);
            r_key      <= i_session_key[KEY_BITS-1:0];
            r_status   <= sts_status_code(i_status_char);
            r_elapsed  <= i_elapsed_seconds;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_free     <= 1'b0;
            r_free_idx <= '0;
            r_count    <= '0;
            r_any_drop <= 1'b0;
        end else if (i_cmd.cmp_en) begin
            // Slots are visited in ascending order, so the first match wins.
            if (cmp_hit && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= i_cmp_idx;
            end
            if (!cmp_used && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= i_cmp_idx;
            end
            r_count    <= r_count + CNT_W'(cmp_kept);
            r_any_drop <= r_any_drop | cmp_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_result <= '{outcome:           res_outcome,
                          slot_index:        3'(res_slot),
                          active_count:      count_ext[3:0],
                          load_tier:         sts_load_tier(count_ext),
                          structure_changed: res_changed};
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/sts_ctrl.sv -----
// ---------------------------------------------------------------------------
// Session table controller
// Sequences accept, slot scan, commit and result handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_ctrl import sts_pkg::*; #(
    parameter  int TABLE_SLOTS = 8,
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_dp_cmd           o_cmd,
    output logic [SLOT_W-1:0] o_rd_idx,
    output logic [SLOT_W-1:0] o_cmp_idx
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_idx;
    logic              r_cmp_en;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_cmd.cmp_en = r_cmp_en;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    // The compare index is a registered copy of the read address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_en  <= 1'b0;
            r_cmp_idx <= '0;
        end else begin
            if (o_cmd.load) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN && r_idx != LAST_SLOT) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            r_cmp_en  <= (r_state == ST_SCAN);
            r_cmp_idx <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rd_idx    = r_idx;
    assign o_cmp_idx   = r_cmp_idx;

endmodule

`default_nettype wire

// ----- rtl/core/session_table_snapshot_sync.sv -----
// ---------------------------------------------------------------------------
// Session table with snapshot synchronization
// A new command is accepted only after the previous one has been committed;
// each command is scanned one slot per cycle through the key memory's single
// read port, and its commit waits until the previous result has been taken.
// Reset: synchronous, active low; empties the table and drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "session_table_snapshot_sync_assert.svh"

module session_table_snapshot_sync import sts_pkg::*; #(
    parameter int TABLE_SLOTS = 8,
    parameter int KEY_BITS    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sts_cmd_if.sink    i_cmd,
    sts_res_if.source  o_res
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Every command runs the same sequence. The controller accepts a transfer
    // only when idle, then walks the slots in ascending order, reading one key
    // per cycle. The datapath compares each key in the cycle after its read,
    // records the first matching slot, the first free slot, the number of
    // entries that survive the command and whether any entry is dropped. After
    // the last compare the controller commits the change and loads the result
    // register in the same cycle, provided the previous result has been taken.
    // A waiting result never blocks the next command transfer, only its commit.

    t_dp_cmd           s_cmd;
    logic [SLOT_W-1:0] s_rd_idx;
    logic [SLOT_W-1:0] s_cmp_idx;
    t_result           s_result;

    sts_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (s_cmd),
        .o_rd_idx    (s_rd_idx),
        .o_cmp_idx   (s_cmp_idx)
    );

    // The datapath holds the used and seen flags in flip-flops, the keys and
    // entry metadata in small memories, and the registered result.
    sts_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (s_cmd),
        .i_rd_idx          (s_rd_idx),
        .i_cmp_idx         (s_cmp_idx),
        .i_opcode          (i_cmd.opcode),
        .i_session_key     (i_cmd.session_key),
        .i_status_char     (i_cmd.status_char),
        .i_elapsed_seconds (i_cmd.elapsed_seconds),
        .o_result          (s_result)
    );

    assign o_res.outcome           = s_result.outcome;
    assign o_res.slot_index        = s_result.slot_index;
    assign o_res.active_count      = s_result.active_count;
    assign o_res.load_tier         = s_result.load_tier;
    assign o_res.structure_changed = s_result.structure_changed;

    // A command transfer starts the scan, so the handshake must close behind it.
    `STS_ASSERT_NEXT(a_ready_closes, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "ready stayed high after a command transfer")

    // The commit can never follow directly on a command transfer.
    `STS_ASSERT_NEXT(a_no_early_commit, i_cmd.valid && i_cmd.ready, !s_cmd.apply, "commit issued without a scan")

    // A new result may only be loaded when the old one is gone or leaving.
    `STS_ASSERT_SAME(a_commit_free, s_cmd.apply, !o_res.valid || o_res.ready, "result overwritten before transfer")

    // Only inserts, removes, clears and sweeps can change the table's structure.
    `STS_ASSERT_SAME(a_changed_kind, o_res.valid && o_res.structure_changed, o_res.outcome == OC_INSERTED || o_res.outcome == OC_REMOVED || o_res.outcome == OC_CLEARED || o_res.outcome == OC_SWEPT, "structure change flagged on wrong outcome")

endmodule

`default_nettype wire
